FILE: rtl/brb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brb_pkg
// Shared constants, codes and control types for the byte ring buffer.
// ----------------------------------------------------------------------------
package brb_pkg;

    localparam int STORE_DEPTH      = 4096;
    localparam int MAX_ACCESS_BYTES = 8;

    localparam int PTR_W      = $clog2(STORE_DEPTH);
    localparam int COUNT_W    = 12;
    localparam int DATA_W     = 64;
    localparam int SPACE_W    = 12;
    localparam int CMD_W      = 3;
    localparam int STATUS_W   = 2;
    localparam int DATA_BYTES = DATA_W / 8;
    localparam int LEFT_W     = $clog2(DATA_BYTES + 1);
    localparam int LANE_W     = $clog2(DATA_BYTES);
    localparam int CMP_W      = ((PTR_W > COUNT_W) ? PTR_W : COUNT_W) + 1;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE  = 3'd0,
        CMD_READ   = 3'd1,
        CMD_SKIP   = 3'd2,
        CMD_COMMIT = 3'd3,
        CMD_REWIND = 3'd4,
        CMD_QUERY  = 3'd5
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_SPACE = 2'd1,
        ST_COUNT = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_WRITE,
        S_READ,
        S_DRAIN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic check;
        logic wr_step;
        logic rd_step;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic go_write;
        logic go_read;
        logic last;
        logic out_free;
    } t_dp_stat;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] q;
        if (p == PTR_W'(STORE_DEPTH - 1)) begin
            q = '0;
        end else begin
            q = p + PTR_W'(1);
        end
        return q;
    endfunction

endpackage

FILE: rtl/brb_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brb_in_if
// Command channel: valid/ready handshake with command payload.
// ----------------------------------------------------------------------------
interface brb_in_if;
    logic                          valid;
    logic                          ready;
    logic [brb_pkg::CMD_W-1:0]     cmd;
    logic [brb_pkg::DATA_W-1:0]    write_data;
    logic [brb_pkg::COUNT_W-1:0]   byte_count;

    modport source (output valid, cmd, write_data, byte_count, input ready);
    modport sink   (input valid, cmd, write_data, byte_count, output ready);
endinterface

FILE: rtl/brb_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brb_out_if
// Result channel: valid/ready handshake with result payload.
// ----------------------------------------------------------------------------
interface brb_out_if;
    logic                          valid;
    logic                          ready;
    logic [brb_pkg::DATA_W-1:0]    read_data;
    logic [brb_pkg::STATUS_W-1:0]  status;
    logic [brb_pkg::SPACE_W-1:0]   free_space;
    logic [brb_pkg::SPACE_W-1:0]   readable_space;

    modport source (output valid, read_data, status, free_space, readable_space,
                    input ready);
    modport sink   (input valid, read_data, status, free_space, readable_space,
                    output ready);
endinterface

FILE: rtl/byte_ring_buffer_with_read_commit_core.sv
`timescale 1ns / 1ps
// Flow: each transaction goes from acceptance through the check and, for a write or
//   read, its byte steps (a read adds a drain state) to the result register.
// Throughput: one transaction at a time, one byte per cycle through the store's
//   single write/read port; a new transaction is taken while a result waits.
// Reset: synchronous active-low; pointers and handshake state clear, store
//   contents stay undefined (no clearing pass).
// ----------------------------------------------------------------------------
// byte_ring_buffer_with_read_commit_core
// Circular byte FIFO with speculative read, commit and rewind.
// ----------------------------------------------------------------------------
module byte_ring_buffer_with_read_commit_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    brb_in_if.sink    i_req,
    brb_out_if.source o_rsp
);

    brb_pkg::t_dp_cmd  w_cmd;
    brb_pkg::t_dp_stat w_stat;
    logic              w_in_ready;

    brb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_stat     (w_stat),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    brb_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_in_cmd         (i_req.cmd),
        .i_write_data     (i_req.write_data),
        .i_byte_count     (i_req.byte_count),
        .i_out_ready      (o_rsp.ready),
        .o_out_valid      (o_rsp.valid),
        .o_read_data      (o_rsp.read_data),
        .o_status         (o_rsp.status),
        .o_free_space     (o_rsp.free_space),
        .o_readable_space (o_rsp.readable_space)
    );

    assign i_req.ready = w_in_ready;

endmodule

FILE: rtl/brb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brb_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module brb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/brb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brb_ctrl
// Sequencer for the ring buffer: accept, check, byte steps, result.
// ----------------------------------------------------------------------------
module brb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  brb_pkg::t_dp_stat i_stat,
    output logic              o_in_ready,
    output brb_pkg::t_dp_cmd  o_cmd
);

    brb_pkg::t_state r_state;
    brb_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= brb_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            brb_pkg::S_IDLE: begin
                if (i_in_valid) n_state = brb_pkg::S_CHECK;
            end
            brb_pkg::S_CHECK: begin
                priority if (i_stat.go_write) n_state = brb_pkg::S_WRITE;
                else if (i_stat.go_read)      n_state = brb_pkg::S_READ;
                else                          n_state = brb_pkg::S_DONE;
            end
            brb_pkg::S_WRITE: begin
                if (i_stat.last) n_state = brb_pkg::S_DONE;
            end
            brb_pkg::S_READ: begin
                if (i_stat.last) n_state = brb_pkg::S_DRAIN;
            end
            brb_pkg::S_DRAIN: begin
                n_state = brb_pkg::S_DONE;
            end
            brb_pkg::S_DONE: begin
                if (i_stat.out_free) n_state = brb_pkg::S_IDLE;
            end
            default: n_state = brb_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            brb_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            brb_pkg::S_CHECK: o_cmd.check   = 1'b1;
            brb_pkg::S_WRITE: o_cmd.wr_step = 1'b1;
            brb_pkg::S_READ:  o_cmd.rd_step = 1'b1;
            brb_pkg::S_DRAIN: o_cmd         = '0;
            brb_pkg::S_DONE:  o_cmd.load_out = i_stat.out_free;
            default:          o_cmd         = '0;
        endcase
    end

endmodule

FILE: rtl/brb_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brb_dp
// Datapath: pointers, space arithmetic, byte store and result register.
// ----------------------------------------------------------------------------
module brb_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  brb_pkg::t_dp_cmd              i_cmd,
    output brb_pkg::t_dp_stat             o_stat,
    input  logic [brb_pkg::CMD_W-1:0]     i_in_cmd,
    input  logic [brb_pkg::DATA_W-1:0]    i_write_data,
    input  logic [brb_pkg::COUNT_W-1:0]   i_byte_count,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [brb_pkg::DATA_W-1:0]    o_read_data,
    output logic [brb_pkg::STATUS_W-1:0]  o_status,
    output logic [brb_pkg::SPACE_W-1:0]   o_free_space,
    output logic [brb_pkg::SPACE_W-1:0]   o_readable_space
);

    localparam int PW = brb_pkg::PTR_W;
    localparam int CW = brb_pkg::CMP_W;

    // item registers
    brb_pkg::t_cmd                   r_cmd,    n_cmd;
    logic [brb_pkg::DATA_W-1:0]      r_wdata,  n_wdata;
    logic [brb_pkg::COUNT_W-1:0]     r_count,  n_count;
    logic [brb_pkg::LEFT_W-1:0]      r_left,   n_left;
    logic [brb_pkg::DATA_W-1:0]      r_rdata,  n_rdata;
    brb_pkg::t_status                r_status, n_status;
    logic                            r_pend,   n_pend;

    // pointers
    logic [PW-1:0] r_wp, n_wp;
    logic [PW-1:0] r_rp, n_rp;
    logic [PW-1:0] r_cs, n_cs;

    // result register
    logic                            r_ov,   n_ov;
    logic [brb_pkg::DATA_W-1:0]      r_ordata, n_ordata;
    logic [brb_pkg::STATUS_W-1:0]    r_ostat,  n_ostat;
    logic [brb_pkg::SPACE_W-1:0]     r_ofree,  n_ofree;
    logic [brb_pkg::SPACE_W-1:0]     r_oread,  n_oread;

    logic [CW-1:0]                   w_free;
    logic [CW-1:0]                   w_readable;
    logic [CW-1:0]                   w_count;
    logic [CW-1:0]                   w_skip_sum;
    brb_pkg::t_status                w_status;
    logic [brb_pkg::LANE_W-1:0]      w_lane;
    logic [brb_pkg::LEFT_W-1:0]      w_left_m1;
    logic                            w_we;
    logic                            w_re;
    logic [7:0]                      w_ram_wdata;
    logic [7:0]                      w_ram_rdata;

    always_comb begin
        if (r_wp >= r_cs) begin
            w_free = CW'(brb_pkg::STORE_DEPTH - 1) - CW'(r_wp) + CW'(r_cs);
        end else begin
            w_free = CW'(r_cs) - CW'(r_wp) - CW'(1);
        end
        if (r_rp > r_wp) begin
            w_readable = CW'(brb_pkg::STORE_DEPTH) - CW'(r_rp) + CW'(r_wp);
        end else begin
            w_readable = CW'(r_wp) - CW'(r_rp);
        end
    end

    assign w_count    = CW'(r_count);
    assign w_skip_sum = CW'(r_rp) + w_count;

    always_comb begin
        w_status = brb_pkg::ST_OK;
        unique case (r_cmd)
            brb_pkg::CMD_WRITE: begin
                priority if (w_count > CW'(brb_pkg::MAX_ACCESS_BYTES))
                    w_status = brb_pkg::ST_COUNT;
                else if (w_count > w_free)
                    w_status = brb_pkg::ST_SPACE;
            end
            brb_pkg::CMD_READ: begin
                priority if (w_count > CW'(brb_pkg::MAX_ACCESS_BYTES))
                    w_status = brb_pkg::ST_COUNT;
                else if (w_count > w_readable)
                    w_status = brb_pkg::ST_SPACE;
            end
            brb_pkg::CMD_SKIP: begin
                if (w_count > w_readable) w_status = brb_pkg::ST_SPACE;
            end
            default: w_status = brb_pkg::ST_OK;
        endcase
    end

    assign o_stat.go_write = (r_cmd == brb_pkg::CMD_WRITE) && (w_status == brb_pkg::ST_OK)
                             && (r_count != '0);
    assign o_stat.go_read  = (r_cmd == brb_pkg::CMD_READ) && (w_status == brb_pkg::ST_OK)
                             && (r_count != '0);
    assign o_stat.last     = (r_left == brb_pkg::LEFT_W'(1));
    assign o_stat.out_free = !r_ov || i_out_ready;

    assign w_left_m1   = r_left - brb_pkg::LEFT_W'(1);
    assign w_lane      = w_left_m1[brb_pkg::LANE_W-1:0];
    assign w_ram_wdata = r_wdata[8*w_lane +: 8];
    assign w_we        = i_cmd.wr_step;
    assign w_re        = i_cmd.rd_step;

    brb_ram #(
        .WIDTH (8),
        .DEPTH (brb_pkg::STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_wp),
        .i_wdata (w_ram_wdata),
        .i_re    (w_re),
        .i_raddr (r_rp),
        .o_rdata (w_ram_rdata)
    );

    always_comb begin
        n_cmd    = r_cmd;
        n_wdata  = r_wdata;
        n_count  = r_count;
        n_left   = r_left;
        n_rdata  = r_rdata;
        n_status = r_status;
        n_pend   = i_cmd.rd_step;
        n_wp     = r_wp;
        n_rp     = r_rp;
        n_cs     = r_cs;

        if (i_cmd.load) begin
            n_cmd   = brb_pkg::t_cmd'(i_in_cmd);
            n_wdata = i_write_data;
            n_count = i_byte_count;
            n_rdata = '0;
        end

        if (i_cmd.check) begin
            n_status = w_status;
            n_left   = r_count[brb_pkg::LEFT_W-1:0];
            if (w_status == brb_pkg::ST_OK) begin
                unique case (r_cmd)
                    brb_pkg::CMD_SKIP: begin
                        if (w_skip_sum >= CW'(brb_pkg::STORE_DEPTH)) begin
                            n_rp = PW'(w_skip_sum - CW'(brb_pkg::STORE_DEPTH));
                        end else begin
                            n_rp = PW'(w_skip_sum);
                        end
                    end
                    brb_pkg::CMD_COMMIT: n_cs = r_rp;
                    brb_pkg::CMD_REWIND: n_rp = r_cs;
                    default: n_rp = r_rp;
                endcase
            end
        end

        if (i_cmd.wr_step) begin
            n_wp   = brb_pkg::ptr_inc(r_wp);
            n_left = w_left_m1;
        end

        if (i_cmd.rd_step) begin
            n_rp   = brb_pkg::ptr_inc(r_rp);
            n_left = w_left_m1;
        end

        if (r_pend) begin
            n_rdata = {r_rdata[brb_pkg::DATA_W-9:0], w_ram_rdata};
        end
    end

    always_comb begin
        n_ov     = r_ov;
        n_ordata = r_ordata;
        n_ostat  = r_ostat;
        n_ofree  = r_ofree;
        n_oread  = r_oread;
        if (i_cmd.load_out) begin
            n_ov     = 1'b1;
            n_ordata = r_rdata;
            n_ostat  = r_status;
            n_ofree  = w_free[brb_pkg::SPACE_W-1:0];
            n_oread  = w_readable[brb_pkg::SPACE_W-1:0];
        end else if (i_out_ready) begin
            n_ov = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_cs   <= '0;
            r_pend <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            r_wp   <= n_wp;
            r_rp   <= n_rp;
            r_cs   <= n_cs;
            r_pend <= n_pend;
            r_ov   <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_wdata  <= n_wdata;
        r_count  <= n_count;
        r_left   <= n_left;
        r_rdata  <= n_rdata;
        r_status <= n_status;
        r_ordata <= n_ordata;
        r_ostat  <= n_ostat;
        r_ofree  <= n_ofree;
        r_oread  <= n_oread;
    end

    assign o_out_valid      = r_ov;
    assign o_read_data      = r_ordata;
    assign o_status         = r_ostat;
    assign o_free_space     = r_ofree;
    assign o_readable_space = r_oread;

endmodule

FILE: dv/tb_byte_ring_buffer_with_read_commit_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_byte_ring_buffer_with_read_commit_core
// Self-checking bench for the byte ring buffer with speculative read, commit
// and rewind. A scoreboard tracks pointers and store contents and predicts
// every response. Tests cover edge cases, a fill with pointer wrap, receiver
// backpressure, and random traffic under several idle/stall mixes.
// ----------------------------------------------------------------------------
module tb_byte_ring_buffer_with_read_commit_core;
    import brb_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED_A = 3'd6;
    localparam logic [CMD_W-1:0] CMD_UNUSED_B = 3'd7;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_PAD   = 16;
    localparam int PHASE_ITEMS = 80;

    typedef struct packed {
        logic [DATA_W-1:0]  read_data;
        t_status            status;
        logic [SPACE_W-1:0] free_space;
        logic [SPACE_W-1:0] readable_space;
    } t_ring_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    brb_in_if  req_if ();
    brb_out_if rsp_if ();

    byte_ring_buffer_with_read_commit_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // scoreboard state
    logic [7:0]       ring_mem [STORE_DEPTH];
    logic [PTR_W-1:0] wr_ptr     = '0;
    logic [PTR_W-1:0] rd_ptr     = '0;
    logic [PTR_W-1:0] commit_ptr = '0;
    t_ring_result     pending_ring_results [$];

    int err_cnt       = 0;
    int cycle_cnt     = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int rx_hold       = 0;

    function automatic logic [SPACE_W-1:0] room_left();
        return SPACE_W'(STORE_DEPTH - 1) - SPACE_W'(wr_ptr - commit_ptr);
    endfunction

    function automatic logic [SPACE_W-1:0] bytes_readable();
        return SPACE_W'(wr_ptr - rd_ptr);
    endfunction

    function automatic logic [DATA_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic t_ring_result ring_model_step(input logic [CMD_W-1:0]   op,
                                                     input logic [DATA_W-1:0]  wdata,
                                                     input logic [COUNT_W-1:0] cnt);
        t_ring_result r;
        int sh;
        r.read_data = '0;
        r.status    = ST_OK;
        case (op)
            CMD_WRITE: begin
                if (cnt > MAX_ACCESS_BYTES) begin
                    r.status = ST_COUNT;
                end else if (cnt > room_left()) begin
                    r.status = ST_SPACE;
                end else begin
                    for (int i = 0; i < int'(cnt); i++) begin
                        sh = 8 * (int'(cnt) - 1 - i);
                        ring_mem[wr_ptr] = 8'(wdata >> sh);
                        wr_ptr = wr_ptr + PTR_W'(1);
                    end
                end
            end
            CMD_READ: begin
                if (cnt > MAX_ACCESS_BYTES) begin
                    r.status = ST_COUNT;
                end else if (cnt > bytes_readable()) begin
                    r.status = ST_SPACE;
                end else begin
                    for (int i = 0; i < int'(cnt); i++) begin
                        r.read_data = {r.read_data[DATA_W-9:0], ring_mem[rd_ptr]};
                        rd_ptr = rd_ptr + PTR_W'(1);
                    end
                end
            end
            CMD_SKIP: begin
                if (cnt > bytes_readable()) begin
                    r.status = ST_SPACE;
                end else begin
                    rd_ptr = rd_ptr + PTR_W'(cnt);
                end
            end
            CMD_COMMIT: commit_ptr = rd_ptr;
            CMD_REWIND: rd_ptr = commit_ptr;
            default: ;
        endcase
        r.free_space     = room_left();
        r.readable_space = bytes_readable();
        return r;
    endfunction

    task automatic push_cmd(input logic [CMD_W-1:0]   op,
                            input logic [DATA_W-1:0]  wdata,
                            input logic [COUNT_W-1:0] cnt);
        @(negedge i_clk);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid      <= 1'b1;
        req_if.cmd        <= op;
        req_if.write_data <= wdata;
        req_if.byte_count <= cnt;
        @(posedge i_clk);
        while (req_if.ready !== 1'b1) @(posedge i_clk);
        pending_ring_results.push_back(ring_model_step(op, wdata, cnt));
    endtask

    task automatic wait_drain();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (pending_ring_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_PAD) @(posedge i_clk);
    endtask

    task automatic flag_mismatch(input string what, input logic [DATA_W-1:0] want,
                                 input logic [DATA_W-1:0] got);
        err_cnt++;
        if (err_cnt <= 10)
            $display("mismatch %0s: expected %h, got %h at %0t", what, want, got, $time);
    endtask

    task automatic send_random_op();
        int pick;
        logic [COUNT_W-1:0] n;
        pick = $urandom_range(99);
        if (pick < 32) begin
            push_cmd(CMD_WRITE, rand64(), COUNT_W'($urandom_range(1, MAX_ACCESS_BYTES)));
        end else if (pick < 58) begin
            n = COUNT_W'($urandom_range(1, MAX_ACCESS_BYTES));
            if (n > bytes_readable() && bytes_readable() != 0) n = bytes_readable();
            push_cmd(CMD_READ, rand64(), n);
        end else if (pick < 66) begin
            push_cmd(CMD_SKIP, rand64(), COUNT_W'($urandom_range(0, 12)));
        end else if (pick < 76) begin
            push_cmd(CMD_COMMIT, rand64(), COUNT_W'($urandom_range(0, 15)));
        end else if (pick < 80) begin
            push_cmd(CMD_REWIND, rand64(), COUNT_W'($urandom_range(0, 15)));
        end else if (pick < 85) begin
            push_cmd(CMD_W'($urandom_range(CMD_QUERY, CMD_UNUSED_B)), rand64(),
                     COUNT_W'($urandom_range(0, 15)));
        end else if (pick < 92) begin
            push_cmd(CMD_W'($urandom_range(CMD_WRITE, CMD_UNUSED_B)), rand64(),
                     COUNT_W'($urandom_range(0, 16)));
        end else begin
            push_cmd(CMD_W'($urandom_range(CMD_WRITE, CMD_UNUSED_B)), rand64(),
                     COUNT_W'($urandom_range(0, 4095)));
        end
    endtask

    task automatic test_directed_edges();
        send_idle_pct = 0;
        stall_pct     = 0;
        push_cmd(CMD_QUERY,    '0, '0);
        push_cmd(CMD_UNUSED_A, rand64(), 12'd1);
        push_cmd(CMD_UNUSED_B, rand64(), '1);
        push_cmd(CMD_READ,     rand64(), 12'd1);
        push_cmd(CMD_SKIP,     rand64(), 12'd1);
        push_cmd(CMD_READ,     rand64(), 12'd0);
        push_cmd(CMD_SKIP,     rand64(), 12'd0);
        push_cmd(CMD_WRITE,    rand64(), 12'd0);
        push_cmd(CMD_WRITE,    rand64(), 12'd9);
        push_cmd(CMD_WRITE,    '1,       '1);
        push_cmd(CMD_WRITE,    '1,       12'd8);
        push_cmd(CMD_WRITE,    '0,       12'd8);
        push_cmd(CMD_WRITE,    rand64(), 12'd3);
        push_cmd(CMD_READ,     rand64(), 12'd9);
        push_cmd(CMD_READ,     rand64(), '1);
        push_cmd(CMD_READ,     rand64(), 12'd8);
        push_cmd(CMD_READ,     rand64(), 12'd3);
        push_cmd(CMD_REWIND,   rand64(), '1);
        push_cmd(CMD_SKIP,     rand64(), '1);
        push_cmd(CMD_SKIP,     rand64(), 12'd8);
        push_cmd(CMD_READ,     rand64(), 12'd8);
        push_cmd(CMD_COMMIT,   rand64(), '1);
        push_cmd(CMD_READ,     rand64(), 12'd3);
        push_cmd(CMD_REWIND,   '0,       '0);
        push_cmd(CMD_COMMIT,   '0,       '0);
        wait_drain();
    endtask

    task automatic test_fill_and_wrap();
        logic [COUNT_W-1:0] n;
        send_idle_pct = 0;
        stall_pct     = 0;
        while (room_left() != 0) begin
            n = COUNT_W'(MAX_ACCESS_BYTES);
            if (n > room_left()) n = room_left();
            push_cmd(CMD_WRITE, rand64(), n);
        end
        push_cmd(CMD_WRITE, rand64(), 12'd1);
        push_cmd(CMD_QUERY, rand64(), '0);
        // stop three bytes below the top, then read across the wrap
        n = COUNT_W'(STORE_DEPTH - 3) - COUNT_W'(rd_ptr);
        push_cmd(CMD_SKIP, rand64(), n);
        push_cmd(CMD_READ, rand64(), COUNT_W'(MAX_ACCESS_BYTES));
        push_cmd(CMD_REWIND, rand64(), '0);
        // skip lands exactly on the top of the ring
        n = '0 - COUNT_W'(rd_ptr);
        push_cmd(CMD_SKIP, rand64(), n);
        push_cmd(CMD_COMMIT, rand64(), '0);
        push_cmd(CMD_READ, rand64(), COUNT_W'(MAX_ACCESS_BYTES));
        push_cmd(CMD_REWIND, rand64(), '0);
        push_cmd(CMD_SKIP, rand64(), bytes_readable());
        push_cmd(CMD_SKIP, rand64(), 12'd1);
        push_cmd(CMD_COMMIT, rand64(), '0);
        push_cmd(CMD_WRITE, rand64(), COUNT_W'(MAX_ACCESS_BYTES));
        push_cmd(CMD_READ, rand64(), COUNT_W'(MAX_ACCESS_BYTES));
        push_cmd(CMD_COMMIT, rand64(), '0);
        wait_drain();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        stall_pct     = 0;
        rx_hold       = 400;
        repeat (24) send_random_op();
        wait_drain();
    endtask

    task automatic test_random_traffic();
        int idle_mix  [4] = '{0, 75, 0, 16};
        int stall_mix [4] = '{0, 0, 75, 16};
        for (int p = 0; p < 4; p++) begin
            send_idle_pct = idle_mix[p];
            stall_pct     = stall_mix[p];
            repeat (PHASE_ITEMS) send_random_op();
            wait_drain();
        end
    endtask

    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            rsp_if.ready <= 1'b0;
            rx_hold      <= rx_hold - 1;
        end else begin
            rsp_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_ring_result want;
        if (i_rst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            if (pending_ring_results.size() == 0) begin
                flag_mismatch("result with no transaction pending", '0, rsp_if.read_data);
            end else begin
                want = pending_ring_results.pop_front();
                if (rsp_if.read_data !== want.read_data)
                    flag_mismatch("read_data", want.read_data, rsp_if.read_data);
                if (rsp_if.status !== want.status)
                    flag_mismatch("status", DATA_W'(want.status), DATA_W'(rsp_if.status));
                if (rsp_if.free_space !== want.free_space)
                    flag_mismatch("free_space", DATA_W'(want.free_space),
                                  DATA_W'(rsp_if.free_space));
                if (rsp_if.readable_space !== want.readable_space)
                    flag_mismatch("readable_space", DATA_W'(want.readable_space),
                                  DATA_W'(rsp_if.readable_space));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < STORE_DEPTH; i++) ring_mem[i] = '0;
        i_rst_n           = 1'b0;
        req_if.valid      = 1'b0;
        req_if.cmd        = CMD_QUERY;
        req_if.write_data = '0;
        req_if.byte_count = '0;
        rsp_if.ready      = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_edges();
        test_fill_and_wrap();
        test_backpressure();
        test_random_traffic();
        if (err_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/brb_pkg.sv
rtl/brb_in_if.sv
rtl/brb_out_if.sv
rtl/brb_ram.sv
rtl/brb_ctrl.sv
rtl/brb_dp.sv
rtl/byte_ring_buffer_with_read_commit_core.sv
dv/tb_byte_ring_buffer_with_read_commit_core.sv
